// File: src/ssrf_pkg.sv
// shared types, register indexes and reset values of the spike reject filter
`default_nettype none

package ssrf_pkg;

   // configuration port
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CsrLowLimit       = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrHighLimit      = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrSpikeThreshold = 2'd2;

   // register values after reset
   localparam logic signed [15:0] LowLimitReset       = 16'sd3840;
   localparam logic signed [15:0] HighLimitReset      = 16'sd6400;
   localparam logic [31:0]        SpikeThresholdReset = 32'd392656;

   // result queue depth, at least two so a final sample can push both words
   localparam int OutFifoDepth = 4;

   // input word
   typedef struct packed {
      logic [47:0]        time_tag;
      logic signed [15:0] temperature;
      logic               last_sample;
   } req_type;

   // result word
   typedef struct packed {
      logic [47:0]        out_time_tag;
      logic signed [15:0] out_temperature;
      logic               keep;
      logic               last_result;
   } rsp_type;

endpackage

`default_nettype wire

// File: src/sample_spike_reject_filter_core.sv
// top level of the temperature spike reject filter
//
// Usage: temperature samples enter as req_data words on a valid/ready channel;
// decisions leave as rsp_data words on a valid/ready channel. Each sample is
// decided once its successor has arrived, so the word for a sample comes out
// after the next input word. A word marked last_sample releases up to two
// results: the decision for any held sample and then its own (last_result set).
// Limits and spike threshold are written through the csr_ port while idle.
// Pipeline: the input register holds the word and the neighbor difference
// magnitude; the next stage squares it (one 16x16 multiplier), compares and
// pushes results into a four word queue that drives rsp_valid. Throughput
// is one word per cycle while the queue has room; a final sample behind a
// held one needs two queue slots and leaves as two output words.
// When the receiver stalls, the queue fills and req_ready drops once the
// input register cannot advance. Reset empties the pipeline and the queue,
// forgets any held sample and restores the default limits and threshold.
`default_nettype none

module sample_spike_reject_filter_core #(
   parameter int FIFO_DEPTH = ssrf_pkg::OutFifoDepth
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  ssrf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output ssrf_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_write_en,
   input  wire [ssrf_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire [ssrf_pkg::CsrDataWidth-1:0]     csr_wdata
);

   localparam int CntW = $clog2(FIFO_DEPTH + 1);

   // configuration registers
   logic signed [15:0] low_limit_ff, high_limit_ff;
   logic [31:0]        threshold_ff;

   // input stage
   logic               accept;
   logic signed [15:0] prev_temp_ff;
   logic signed [16:0] diff;
   logic signed [16:0] diff_neg;
   logic [15:0]        mag;
   logic               s1_valid_ff, s1_valid_in;
   ssrf_pkg::req_type  s1_data_ff;
   logic [15:0]        s1_mag_ff;

   // decision stage and held sample
   logic               held_valid_ff, held_valid_in;
   logic               held_first_ff, held_first_in;
   logic               held_back_ff, held_back_in;
   logic signed [15:0] held_temp_ff;
   logic [47:0]        held_time_ff;
   logic [31:0]        sq;
   logic               fwd;
   logic               held_in_range, cur_in_range;
   logic               held_reject, cur_reject;
   logic [1:0]         n_push;
   logic [1:0]         push_count;
   logic [CntW-1:0]    free_count;
   logic               fire;
   ssrf_pkg::rsp_type  held_rsp, cur_rsp, slot0;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= ssrf_pkg::LowLimitReset;
         high_limit_ff <= ssrf_pkg::HighLimitReset;
         threshold_ff  <= ssrf_pkg::SpikeThresholdReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ssrf_pkg::CsrLowLimit:       low_limit_ff  <= csr_wdata[15:0];
            ssrf_pkg::CsrHighLimit:      high_limit_ff <= csr_wdata[15:0];
            ssrf_pkg::CsrSpikeThreshold: threshold_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake of the input register
   assign req_ready   = !s1_valid_ff || fire;
   assign accept      = req_valid && req_ready;
   assign s1_valid_in = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);

   // neighbor difference magnitude against the previous word
   assign diff     = {prev_temp_ff[15], prev_temp_ff}
                   - {req_data.temperature[15], req_data.temperature};
   assign diff_neg = -diff;
   assign mag      = diff[16] ? diff_neg[15:0] : diff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff   <= req_data;
         s1_mag_ff    <= mag;
         prev_temp_ff <= req_data.temperature;
      end
   end

   // squared difference and range tests
   assign sq            = {16'd0, s1_mag_ff} * {16'd0, s1_mag_ff};
   assign fwd           = sq > threshold_ff;
   assign held_in_range = (held_temp_ff >= low_limit_ff) && (held_temp_ff <= high_limit_ff);
   assign cur_in_range  = (s1_data_ff.temperature >= low_limit_ff)
                       && (s1_data_ff.temperature <= high_limit_ff);

   // decisions: held sample vs both neighbors, opener vs next, final vs one
   assign held_reject = !held_in_range || (held_first_ff ? fwd : (held_back_ff && fwd));
   assign cur_reject  = !cur_in_range || (held_valid_ff && fwd);

   always_comb begin
      held_rsp.out_time_tag    = held_time_ff;
      held_rsp.out_temperature = held_temp_ff;
      held_rsp.keep            = !held_reject;
      held_rsp.last_result     = 1'b0;
      cur_rsp.out_time_tag     = s1_data_ff.time_tag;
      cur_rsp.out_temperature  = s1_data_ff.temperature;
      cur_rsp.keep             = !cur_reject;
      cur_rsp.last_result      = 1'b1;
   end

   assign slot0      = held_valid_ff ? held_rsp : cur_rsp;
   assign n_push     = {1'b0, held_valid_ff} + {1'b0, s1_data_ff.last_sample};
   assign fire       = s1_valid_ff && (free_count >= CntW'(n_push));
   assign push_count = fire ? n_push : 2'd0;

   // held sample update
   always_comb begin
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      held_back_in  = held_back_ff;
      if (fire) begin
         if (s1_data_ff.last_sample) begin
            held_valid_in = 1'b0;
            held_first_in = 1'b0;
            held_back_in  = 1'b0;
         end else begin
            held_valid_in = 1'b1;
            held_first_in = !held_valid_ff;
            held_back_in  = held_valid_ff && fwd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         held_back_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         held_back_ff  <= held_back_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_temp_ff <= s1_data_ff.temperature;
         held_time_ff <= s1_data_ff.time_tag;
      end
   end

   // result queue
   ssrf_out_fifo #(
      .Depth (FIFO_DEPTH)
   ) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (slot0),
      .push_data1 (cur_rsp),
      .free_count (free_count),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data)
   );

`ifndef SYNTH
   // a final sample closes the series
   assert property (@(posedge clock) disable iff (reset)
      fire && s1_data_ff.last_sample |=> !held_valid_ff)
      else $error("held sample survived a final sample");

   // a first-of-series flag only exists on a held sample
   assert property (@(posedge clock) disable iff (reset)
      held_first_ff |-> held_valid_ff)
      else $error("first flag without held sample");

   // a back spike is only recorded against a real predecessor
   assert property (@(posedge clock) disable iff (reset)
      held_back_ff |-> held_valid_ff && !held_first_ff)
      else $error("back spike on a series opener");

   // a double push only when the queue has room for both words
   assert property (@(posedge clock) disable iff (reset)
      push_count == 2'd2 |-> free_count >= CntW'(2))
      else $error("result queue overflow");

   // stall on input only when the input register is occupied
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && !fire)
      else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

// File: src/ssrf_out_fifo.sv
// result queue taking up to two words per cycle and giving one per cycle while not empty and pop_ready is high
`default_nettype none

module ssrf_out_fifo #(
   parameter int Depth = ssrf_pkg::OutFifoDepth
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire [1:0]                   push_count,
   input  ssrf_pkg::rsp_type           push_data0,
   input  ssrf_pkg::rsp_type           push_data1,
   output logic [$clog2(Depth+1)-1:0]  free_count,
   output logic                        pop_valid,
   input  wire                         pop_ready,
   output ssrf_pkg::rsp_type           pop_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   ssrf_pkg::rsp_type mem_ff [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx1, wr_ptr_nx2;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      logic [PtrW-1:0] r;
      if (p == PtrW'(Depth - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign wr_ptr_nx1 = ptr_next(wr_ptr_ff);
   assign wr_ptr_nx2 = ptr_next(wr_ptr_nx1);

   assign pop        = pop_valid && pop_ready;
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign free_count = CntW'(Depth) - count_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_count == 2'd1) begin
         wr_ptr_in = wr_ptr_nx1;
      end else if (push_count == 2'd2) begin
         wr_ptr_in = wr_ptr_nx2;
      end
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push_count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, second word lands behind the first
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_nx1] <= push_data1;
      end
   end

endmodule

`default_nettype wire

// File: test/testbench.sv
// self-checking testbench of the temperature spike reject filter core
module testbench;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   ssrf_pkg::req_type                  req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   ssrf_pkg::rsp_type                  rsp_data;
   logic                               csr_write_en = 1'b0;
   logic [ssrf_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [ssrf_pkg::CsrDataWidth-1:0]  csr_wdata = '0;

   sample_spike_reject_filter_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // limits and threshold as the block should hold them
   logic signed [15:0] low_lim   = ssrf_pkg::LowLimitReset;
   logic signed [15:0] high_lim  = ssrf_pkg::HighLimitReset;
   logic [31:0]        threshold = ssrf_pkg::SpikeThresholdReset;

   // sample waiting for its successor
   logic               prev_valid      = 1'b0;
   logic signed [15:0] prev_temp       = '0;
   logic [47:0]        prev_stamp      = '0;
   logic               prev_back_spike = 1'b0;
   logic               prev_opens      = 1'b0;

   ssrf_pkg::req_type pending_q[$];
   ssrf_pkg::rsp_type decisions_q[$];
   int      queued_total = 0;
   int      taken_total  = 0;
   int      errors       = 0;

   logic req_fired = 1'b0;
   int   req_wait  = 0;
   int   req_calm  = 0;
   int   rsp_hold  = 0;
   int   rsp_calm  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic bit in_limits(input logic signed [15:0] t);
      return t >= low_lim && t <= high_lim;
   endfunction

   function automatic logic signed [15:0] clip16(input int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic note_error(input string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic push_sample(input logic [47:0] stamp, input logic signed [15:0] temp,
                              input logic last);
      ssrf_pkg::req_type w;
      w.time_tag    = stamp;
      w.temperature = temp;
      w.last_sample = last;
      pending_q.push_back(w);
      queued_total++;
   endtask

   // limit registers are written with junk in the unused upper bits
   task automatic set_limits(input logic signed [15:0] lo, input logic signed [15:0] hi,
                             input logic [31:0] thr);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= ssrf_pkg::CsrLowLimit;
      csr_wdata    <= {16'($urandom), lo};
      @(negedge clock);
      csr_index    <= ssrf_pkg::CsrHighLimit;
      csr_wdata    <= {16'($urandom), hi};
      @(negedge clock);
      csr_index    <= ssrf_pkg::CsrSpikeThreshold;
      csr_wdata    <= thr;
      @(negedge clock);
      csr_write_en <= 1'b0;
      low_lim   = lo;
      high_lim  = hi;
      threshold = thr;
   endtask

   // wait for every word to be taken and every decision to come back
   task automatic wait_drained();
      int guard;
      guard = 0;
      do @(negedge clock); while (taken_total != queued_total);
      while (decisions_q.size() != 0 && guard < 1000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
   endtask

   // series of random length around a base temperature, with spikes and noise
   task automatic add_series(input int count);
      int          made, len, root, base, v, r, k;
      logic [47:0] stamp;
      root = int'($sqrt(real'(threshold)));
      if (root > 65535) root = 65535;
      made  = 0;
      stamp = 48'({$urandom, $urandom});
      while (made < count) begin
         r = $urandom_range(0, 9);
         if (r == 0) len = 1;
         else if (r == 1) len = $urandom_range(13, 40);
         else len = $urandom_range(2, 12);
         if (low_lim <= high_lim)
            base = int'(low_lim) + int'($urandom_range(0, int'(high_lim) - int'(low_lim)));
         else
            base = int'($urandom_range(0, 65535)) - 32768;
         for (k = 0; k < len; k++) begin
            r = $urandom_range(0, 19);
            if (r < 11)
               v = base + int'($urandom_range(0, 2 * root + 2)) - root - 1;
            else if (r < 14)
               v = base + ($urandom_range(0, 1) ? 1 : -1)
                   * (root + 1 + int'($urandom_range(0, 2 * root + 1)));
            else if (r < 16)
               v = ($urandom_range(0, 1) ? int'(low_lim) : int'(high_lim))
                   + int'($urandom_range(0, 4)) - 2;
            else if (r < 18)
               v = base + ($urandom_range(0, 1) ? 1 : -1) * (root + int'($urandom_range(0, 1)));
            else
               v = int'($urandom_range(0, 65535)) - 32768;
            push_sample(stamp, clip16(v), k == len - 1);
            if ($urandom_range(0, 4) == 0) stamp = 48'({$urandom, $urandom});
            else stamp = stamp + $urandom_range(1, 1000);
            made++;
         end
      end
   endtask

   // sender: a word is replaced only after it was taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fired)) begin
         if (req_wait > 0) begin
            req_valid <= 1'b0;
            req_wait  <= req_wait - 1;
         end else if (pending_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_q.pop_front();
            if (req_calm > 0) begin
               req_calm <= req_calm - 1;
               req_wait <= 0;
            end else begin
               req_wait <= idle_len();
               if ($urandom_range(0, 39) == 0) req_calm <= $urandom_range(20, 60);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls with calm stretches
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_calm > 0) rsp_calm <= rsp_calm - 1;
         else if ($urandom_range(0, 49) == 0) rsp_calm <= $urandom_range(20, 60);
         else if ($urandom_range(0, 2) == 0) rsp_hold <= idle_len();
      end
   end

   // predict decisions on accepted samples, check returned decisions
   always @(posedge clock) begin : monitor
      ssrf_pkg::rsp_type want, made;
      logic              fwd, back, opens, reject;
      int                dif;
      longint unsigned   mag;
      req_fired <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         taken_total++;
         back  = 1'b0;
         opens = 1'b1;
         // the held sample is decided now that its successor is known
         if (prev_valid) begin
            dif = int'(prev_temp) - int'(req_data.temperature);
            mag = (dif < 0) ? -dif : dif;
            fwd = (mag * mag) > {32'd0, threshold};
            reject = !in_limits(prev_temp) || (prev_opens ? fwd : (prev_back_spike && fwd));
            made.out_time_tag    = prev_stamp;
            made.out_temperature = prev_temp;
            made.keep            = !reject;
            made.last_result     = 1'b0;
            decisions_q.push_back(made);
            back  = fwd;
            opens = 1'b0;
         end
         if (req_data.last_sample) begin
            reject = !in_limits(req_data.temperature) || (!opens && back);
            made.out_time_tag    = req_data.time_tag;
            made.out_temperature = req_data.temperature;
            made.keep            = !reject;
            made.last_result     = 1'b1;
            decisions_q.push_back(made);
            prev_valid      = 1'b0;
            prev_temp       = '0;
            prev_stamp      = '0;
            prev_back_spike = 1'b0;
            prev_opens      = 1'b0;
         end else begin
            prev_valid      = 1'b1;
            prev_temp       = req_data.temperature;
            prev_stamp      = req_data.time_tag;
            prev_back_spike = back;
            prev_opens      = opens;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (decisions_q.size() == 0) begin
            note_error($sformatf("unexpected word tag %h temp %0d keep %0d last %0d",
                                 rsp_data.out_time_tag, rsp_data.out_temperature,
                                 rsp_data.keep, rsp_data.last_result));
         end else begin
            want = decisions_q.pop_front();
            if (rsp_data.out_time_tag !== want.out_time_tag ||
                rsp_data.out_temperature !== want.out_temperature ||
                rsp_data.keep !== want.keep ||
                rsp_data.last_result !== want.last_result)
               note_error($sformatf({"expected tag %h temp %0d keep %0d last %0d, ",
                                     "got tag %h temp %0d keep %0d last %0d"},
                                    want.out_time_tag, want.out_temperature, want.keep,
                                    want.last_result, rsp_data.out_time_tag,
                                    rsp_data.out_temperature, rsp_data.keep,
                                    rsp_data.last_result));
         end
      end
   end

   initial begin
      logic [47:0] stamp;
      stamp = 48'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default limits: range edges, single samples, spikes on one or both sides
      push_sample(stamp, 16'sd5000, 1'b1);
      push_sample(stamp + 1, 16'sd3839, 1'b1);
      push_sample(stamp + 2, 16'sd3840, 1'b1);
      push_sample(stamp + 3, 16'sd6400, 1'b1);
      push_sample(stamp + 4, 16'sd6401, 1'b1);
      push_sample(stamp + 5, 16'sd5000, 1'b0);
      push_sample(stamp + 6, 16'sd5627, 1'b0);
      push_sample(stamp + 7, 16'sd5000, 1'b0);
      push_sample(stamp + 8, 16'sd5627, 1'b1);
      push_sample(stamp + 9, 16'sd5000, 1'b0);
      push_sample(stamp + 10, 16'sd5626, 1'b0);
      push_sample(stamp + 11, 16'sd5000, 1'b1);
      push_sample(stamp + 12, 16'sd5000, 1'b0);
      push_sample(stamp + 13, 16'sd5700, 1'b0);
      push_sample(stamp + 14, 16'sd5700, 1'b1);
      add_series(200);
      wait_drained();

      // full range, square threshold: equal to the limit is no spike
      set_limits(16'sh8000, 16'sh7fff, 32'd250000);
      push_sample(48'd100, 16'sd1000, 1'b0);
      push_sample(48'd101, 16'sd1500, 1'b1);
      push_sample(48'd102, 16'sd1000, 1'b0);
      push_sample(48'd103, 16'sd1501, 1'b1);
      add_series(200);
      wait_drained();

      // zero threshold: any change is a spike
      set_limits(16'sh8000, 16'sh7fff, 32'd0);
      add_series(200);
      wait_drained();

      // largest threshold: even the widest swing passes
      set_limits(16'sh8000, 16'sh7fff, 32'hffff_ffff);
      push_sample(48'd0, 16'sh8000, 1'b0);
      push_sample(48'hffff_ffff_ffff, 16'sh7fff, 1'b1);
      add_series(200);
      wait_drained();

      // crossed limits reject everything
      set_limits(16'sd100, -16'sd100, 32'd40000);
      add_series(150);
      wait_drained();

      set_limits(-16'sd2560, 16'sd10240, 32'd10000);
      add_series(300);
      wait_drained();

      if (decisions_q.size() != 0)
         note_error($sformatf("%0d decisions never arrived", decisions_q.size()));
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
